FILE: sv/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types, codes and constants of the battery charge estimator.
// ----------------------------------------------------------------------------
package bce_pkg;

  // Field widths
  localparam int MV_W    = 16;
  localparam int MAH_W   = 16;
  localparam int SEC_W   = 16;
  localparam int PCT_W   = 7;
  localparam int CELLS_W = 5;
  localparam int FUNC_W  = 2;
  localparam int RATE_W  = 12;
  localparam int CNT_W   = 8;

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_FAILSAFE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NOMINAL  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESERVE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RATE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLES  = 3'd4;

  localparam logic [RATE_W-1:0] RATE_RESET    = 12'd64;
  localparam logic [CNT_W-1:0]  SAMPLES_RESET = 8'd10;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PERCENT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RECALC  = 2'd2;

  // Cell count: floor(mv / 3200) as (mv * CELL_RECIP) >> CELL_SHIFT, exact for 16 bits
  localparam int          CELL_SHIFT   = 28;
  localparam logic [16:0] CELL_RECIP   = 17'd83887;
  localparam int          CELL_PROD_W  = MV_W + 17;

  // Per-cell discharge curve, highest voltage first
  localparam int MV_TAB_W    = 13;
  localparam int CURVE_MAX   = 16;
  localparam int CURVE_IDX_W = 4;
  localparam logic [MV_TAB_W-1:0] CELL_FLOOR_MV = 13'd3200;
  localparam logic [PCT_W-1:0]    PCT_FULL      = 7'd100;

  localparam logic [MV_TAB_W-1:0] CURVE_MV [CURVE_MAX] = '{
    13'd4200, 13'd4100, 13'd4000, 13'd3950, 13'd3810, 13'd3750, 13'd3700, 13'd3650,
    13'd3430, 13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_MAX] = '{
    7'd100, 7'd95, 7'd85, 7'd77, 7'd56, 7'd50, 7'd25, 7'd17,
    7'd8,   7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
  };

  // Shared divider: 24-bit dividend, 16-bit divisor, two quotient bits a cycle
  localparam int DVD_W       = 24;
  localparam int DVS_W       = 16;
  localparam int MUL_A_W     = 16;
  localparam int MUL_B_W     = 7;
  localparam int DIV_STEPS   = 2;
  localparam int DIV_CYCLES  = DVD_W / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  typedef enum logic [2:0] {
    OP_CELLMV,
    OP_INTERP,
    OP_INIT,
    OP_TOTAL,
    OP_SECS,
    OP_PCT
  } div_op_t;

  typedef struct packed {
    logic    accept;
    logic    div_start;
    logic    capture;
    div_op_t op;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic recalc_ok;
    logic rate_ok;
    logic usable_ok;
    logic out_free;
  } status_t;

endpackage

FILE: sv/bce_if.sv
// ----------------------------------------------------------------------------
// bce_in_if / bce_out_if
// Valid/ready channels carrying one telemetry item and one estimate.
// ----------------------------------------------------------------------------
interface bce_in_if;
  logic                         valid;
  logic                         ready;
  logic [bce_pkg::FUNC_W-1:0]   func;
  logic [bce_pkg::MV_W-1:0]     pack_mv;
  logic [bce_pkg::PCT_W-1:0]    autopilot_percent;

  modport source (output valid, output func, output pack_mv, output autopilot_percent,
                  input ready);
  modport sink   (input valid, input func, input pack_mv, input autopilot_percent,
                  output ready);
endinterface

interface bce_out_if;
  logic                         valid;
  logic                         ready;
  logic [bce_pkg::MAH_W-1:0]    remaining_mah;
  logic [bce_pkg::SEC_W-1:0]    remaining_seconds;
  logic [bce_pkg::PCT_W-1:0]    usable_percent;
  logic [bce_pkg::MAH_W-1:0]    initial_capacity_mah;
  logic [bce_pkg::CELLS_W-1:0]  cells;
  logic                         power_on_done;

  modport source (output valid, output remaining_mah, output remaining_seconds,
                  output usable_percent, output initial_capacity_mah, output cells,
                  output power_on_done, input ready);
  modport sink   (input valid, input remaining_mah, input remaining_seconds,
                  input usable_percent, input initial_capacity_mah, input cells,
                  input power_on_done, output ready);
endinterface

FILE: sv/bce_div.sv
// ----------------------------------------------------------------------------
// bce_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module bce_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bce_pkg::DVD_W-1:0]   dividend,
  input  logic [bce_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [bce_pkg::DVD_W-1:0]   quotient
);
  import bce_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DVD_W-1:0]     quo;
  logic [DVS_W-1:0]     rem_next;
  logic [DVD_W-1:0]     quo_next;
  logic [DVS_W:0]       trial;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial    = {rem_next, quo_next[DVD_W-1]};
      quo_next = {quo_next[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial       = trial - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_LAST;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

FILE: sv/bce_datapath.sv
// ----------------------------------------------------------------------------
// bce_datapath
// Estimator state, curve lookup, operand select, shared divider, result register.
// ----------------------------------------------------------------------------
module bce_datapath #(
  parameter int CURVE_POINTS = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bce_pkg::cmd_t                 cmd,
  output bce_pkg::status_t              st,
  input  logic [bce_pkg::FUNC_W-1:0]    func,
  input  logic [bce_pkg::MV_W-1:0]      pack_mv,
  input  logic [bce_pkg::PCT_W-1:0]     autopilot_percent,
  input  logic [bce_pkg::MAH_W-1:0]     nominal_capacity_mah,
  input  logic [bce_pkg::MAH_W-1:0]     reserve_capacity_mah,
  input  logic [bce_pkg::RATE_W-1:0]    discharge_rate_q4,
  input  logic [bce_pkg::CNT_W-1:0]     power_on_samples,
  input  logic [bce_pkg::CELLS_W-1:0]   cells,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bce_pkg::MAH_W-1:0]     out_remaining_mah,
  output logic [bce_pkg::SEC_W-1:0]     out_remaining_seconds,
  output logic [bce_pkg::PCT_W-1:0]     out_usable_percent,
  output logic [bce_pkg::MAH_W-1:0]     out_initial_capacity_mah,
  output logic [bce_pkg::CELLS_W-1:0]   out_cells,
  output logic                          out_power_on_done
);
  import bce_pkg::*;

  localparam logic [CURVE_IDX_W-1:0] CURVE_LAST = CURVE_IDX_W'(CURVE_POINTS - 1);
  localparam logic [RATE_W-1:0]      RATE_MIN   = 12'd16;
  localparam logic [MUL_B_W-1:0]     MUL_ONE    = 7'd1;
  localparam logic [MUL_B_W-1:0]     MUL_Q4     = 7'd16;
  localparam logic [MUL_B_W-1:0]     MUL_PCT    = 7'd100;
  localparam logic [DVS_W-1:0]       DVS_PCT    = 16'd100;

  // Estimator state
  logic [MV_W-1:0]   peak;
  logic [CNT_W-1:0]  sample_count;
  logic [MAH_W-1:0]  initial_cap;
  logic [PCT_W-1:0]  last_pct;
  logic [FUNC_W-1:0] func_q;

  // Work registers
  logic [MV_W-1:0]   cell_mv;
  logic [PCT_W-1:0]  curve_pct;
  logic [MAH_W-1:0]  rem;
  logic [SEC_W-1:0]  secs;
  logic [PCT_W-1:0]  usable_pct;

  logic sampling_done;

  // Curve lookup
  logic                    hit_found;
  logic [CURVE_IDX_W-1:0]  hit;
  logic [CURVE_IDX_W-1:0]  hit_next;
  logic [MV_TAB_W-1:0]     prev_mv;
  logic [PCT_W-1:0]        prev_pct;
  logic [PCT_W-1:0]        curve_base;
  logic [MUL_A_W-1:0]      curve_a;
  logic [MUL_B_W-1:0]      curve_b;
  logic [DVS_W-1:0]        curve_span;

  // Divider operands
  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [MUL_A_W+MUL_B_W-1:0] product;
  logic [DVS_W-1:0]           divisor;
  logic                       div_done;
  logic [DVD_W-1:0]           quotient;
  logic [DVD_W:0]             interp_sum;
  logic [MAH_W-1:0]           usable_mah;

  assign sampling_done = sample_count >= power_on_samples;
  assign usable_mah    = nominal_capacity_mah - reserve_capacity_mah;

  // Scan from the highest curve voltage downward: the highest index that still
  // lies at or above the cell voltage wins.
  always_comb begin
    hit_found = 1'b0;
    hit       = '0;
    for (int i = 0; i < CURVE_POINTS; i++) begin
      if ({{(MV_W-MV_TAB_W){1'b0}}, CURVE_MV[i]} >= cell_mv) begin
        hit_found = 1'b1;
        hit       = CURVE_IDX_W'(i);
      end
    end
    hit_next = hit + 1'b1;
    if (hit == CURVE_LAST) begin
      prev_mv  = CELL_FLOOR_MV;
      prev_pct = '0;
    end else begin
      prev_mv  = CURVE_MV[hit_next];
      prev_pct = CURVE_PCT[hit_next];
    end
    curve_base = '0;
    curve_a    = '0;
    curve_b    = '0;
    curve_span = DVS_W'(1);
    if (cell_mv <= {{(MV_W-MV_TAB_W){1'b0}}, CELL_FLOOR_MV}) begin
      curve_base = '0;
    end else if (!hit_found) begin
      curve_base = PCT_FULL;
    end else begin
      curve_base = prev_pct;
      curve_a    = cell_mv - {{(MV_W-MV_TAB_W){1'b0}}, prev_mv};
      curve_b    = CURVE_PCT[hit] - prev_pct;
      curve_span = {{(DVS_W-MV_TAB_W){1'b0}}, CURVE_MV[hit] - prev_mv};
    end
  end

  // Operand select ahead of the shared multiplier and divider
  always_comb begin
    unique case (cmd.op)
      OP_CELLMV: begin
        mul_a   = peak;
        mul_b   = MUL_ONE;
        divisor = {{(DVS_W-CELLS_W){1'b0}}, cells};
      end
      OP_INTERP: begin
        mul_a   = curve_a;
        mul_b   = curve_b;
        divisor = curve_span;
      end
      OP_INIT: begin
        mul_a   = nominal_capacity_mah;
        mul_b   = curve_pct;
        divisor = DVS_PCT;
      end
      OP_TOTAL: begin
        mul_a   = initial_cap;
        mul_b   = last_pct;
        divisor = DVS_PCT;
      end
      OP_SECS: begin
        mul_a   = rem;
        mul_b   = MUL_Q4;
        divisor = {{(DVS_W-RATE_W){1'b0}}, discharge_rate_q4};
      end
      OP_PCT: begin
        mul_a   = rem;
        mul_b   = MUL_PCT;
        divisor = usable_mah;
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        divisor = DVS_W'(1);
      end
    endcase
  end

  assign product    = mul_a * mul_b;
  assign interp_sum = {1'b0, quotient} + {{(DVD_W+1-PCT_W){1'b0}}, curve_base};

  bce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({{(DVD_W-MUL_A_W-MUL_B_W){1'b0}}, product}),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Estimator state: sample and percent updates at accept, recalc at capture
  always_ff @(posedge clk) begin
    if (rst) begin
      peak         <= '0;
      sample_count <= '0;
      initial_cap  <= '0;
      last_pct     <= '0;
    end else begin
      if (cmd.accept) begin
        if (func == FUNC_SAMPLE && !sampling_done) begin
          if (pack_mv > peak) begin
            peak <= pack_mv;
          end
          sample_count <= sample_count + 1'b1;
        end else if (func == FUNC_PERCENT) begin
          last_pct <= (autopilot_percent > PCT_FULL) ? PCT_FULL : autopilot_percent;
        end
      end
      if (cmd.capture && cmd.op == OP_INIT) begin
        initial_cap <= quotient[MAH_W-1:0];
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q <= func;
    end
    if (cmd.capture) begin
      unique case (cmd.op)
        OP_CELLMV: cell_mv <= quotient[MV_W-1:0];
        OP_INTERP: curve_pct <= (interp_sum > {{(DVD_W+1-PCT_W){1'b0}}, PCT_FULL}) ?
                                PCT_FULL : interp_sum[PCT_W-1:0];
        OP_INIT: begin
        end
        OP_TOTAL: begin
          rem        <= (quotient[MAH_W-1:0] > reserve_capacity_mah) ?
                        quotient[MAH_W-1:0] - reserve_capacity_mah : '0;
          secs       <= '0;
          usable_pct <= '0;
        end
        OP_SECS: secs <= (|quotient[DVD_W-1:SEC_W]) ? '1 : quotient[SEC_W-1:0];
        OP_PCT: usable_pct <= (quotient > {{(DVD_W-PCT_W){1'b0}}, PCT_FULL}) ?
                              PCT_FULL : quotient[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result register parts the core from the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_remaining_mah        <= rem;
      out_remaining_seconds    <= secs;
      out_usable_percent       <= usable_pct;
      out_initial_capacity_mah <= initial_cap;
      out_cells                <= cells;
      out_power_on_done        <= sampling_done;
    end
  end

  assign st.div_done  = div_done;
  assign st.recalc_ok = func_q == FUNC_RECALC && sampling_done && initial_cap == '0 &&
                        cells != '0 && peak != '0 && nominal_capacity_mah != '0;
  assign st.rate_ok   = discharge_rate_q4 > RATE_MIN;
  assign st.usable_ok = nominal_capacity_mah > reserve_capacity_mah;
  assign st.out_free  = !out_valid || out_ready;

endmodule

FILE: sv/bce_ctrl.sv
// ----------------------------------------------------------------------------
// bce_ctrl
// Sequencer: accepts an item, walks the divide steps, hands off the result.
// ----------------------------------------------------------------------------
module bce_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bce_pkg::status_t  st,
  output bce_pkg::cmd_t     cmd
);
  import bce_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECIDE = 9'b000000010,
    S_CELLMV = 9'b000000100,
    S_INTERP = 9'b000001000,
    S_INIT   = 9'b000010000,
    S_TOTAL  = 9'b000100000,
    S_SECS   = 9'b001000000,
    S_PCT    = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   launched;
  logic   launched_next;
  logic   div_state;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = OP_TOTAL;
    div_state  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = st.recalc_ok ? S_CELLMV : S_TOTAL;
      end
      S_CELLMV: begin
        div_state = 1'b1;
        cmd.op    = OP_CELLMV;
        if (st.div_done) begin
          state_next = S_INTERP;
        end
      end
      S_INTERP: begin
        div_state = 1'b1;
        cmd.op    = OP_INTERP;
        if (st.div_done) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        div_state = 1'b1;
        cmd.op    = OP_INIT;
        if (st.div_done) begin
          state_next = S_TOTAL;
        end
      end
      S_TOTAL: begin
        div_state = 1'b1;
        cmd.op    = OP_TOTAL;
        if (st.div_done) begin
          priority if (st.rate_ok) begin
            state_next = S_SECS;
          end else if (st.usable_ok) begin
            state_next = S_PCT;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SECS: begin
        div_state = 1'b1;
        cmd.op    = OP_SECS;
        if (st.div_done) begin
          state_next = st.usable_ok ? S_PCT : S_FINISH;
        end
      end
      S_PCT: begin
        div_state = 1'b1;
        cmd.op    = OP_PCT;
        if (st.div_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // Launch each divide once, capture on its done pulse
    cmd.div_start = div_state && !launched;
    cmd.capture   = div_state && st.div_done;
    launched_next = div_state && !st.div_done && (launched || cmd.div_start);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  assign in_ready = state == S_IDLE;

endmodule

FILE: sv/battery_charge_estimator_core.sv
// ----------------------------------------------------------------------------
// battery_charge_estimator_core
// Battery charge estimator: remaining mAh, flight time and usable percent.
// ----------------------------------------------------------------------------
// Usage:
//   telemetry carries one item per beat: a pack voltage sample, an autopilot
//   percent update or a recalculate command. estimate returns one beat per
//   item with remaining mAh above reserve, remaining seconds, usable percent,
//   the initial capacity, the cell count and the power-on flag.
//   Configuration goes through the APB port, one 32-bit register per word
//   address; write it only while the block is idle.
//   Sequencing: one shared divider resolves two quotient bits a cycle. An item
//   needs only the total division when both rate and usable capacity are
//   disabled, adds the seconds and percent divisions when they are enabled,
//   and three extra divisions for a recalculate that fixes the initial
//   capacity. One item is in flight at a time; the divider sets the throughput.
//   The result sits in an output register, so the next item is taken while
//   the previous estimate still waits; a stalled receiver holds the core in
//   its final step only once that register is full.
//   Reset (rst, synchronous) clears the peak, sample count, initial capacity
//   and stored percent, and loads the register defaults.
// ----------------------------------------------------------------------------
module battery_charge_estimator_core #(
  parameter int CURVE_POINTS = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  bce_in_if.sink                              telemetry,
  bce_out_if.source                           estimate,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bce_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [bce_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [bce_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import bce_pkg::*;

  // Configuration registers
  logic [MV_W-1:0]    failsafe_pack_mv;
  logic [MAH_W-1:0]   nominal_capacity_mah;
  logic [MAH_W-1:0]   reserve_capacity_mah;
  logic [RATE_W-1:0]  discharge_rate_q4;
  logic [CNT_W-1:0]   power_on_samples;

  // Derived cell count, registered from the failsafe register in the next cycle
  logic [CELLS_W-1:0]     cells;
  logic [CELL_PROD_W-1:0] cell_prod;

  logic                 cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;

  cmd_t    cmd;
  status_t st;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      failsafe_pack_mv     <= '0;
      nominal_capacity_mah <= '0;
      reserve_capacity_mah <= '0;
      discharge_rate_q4    <= RATE_RESET;
      power_on_samples     <= SAMPLES_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_FAILSAFE: failsafe_pack_mv     <= pwdata[MV_W-1:0];
        REG_NOMINAL:  nominal_capacity_mah <= pwdata[MAH_W-1:0];
        REG_RESERVE:  reserve_capacity_mah <= pwdata[MAH_W-1:0];
        REG_RATE:     discharge_rate_q4    <= pwdata[RATE_W-1:0];
        REG_SAMPLES:  power_on_samples     <= pwdata[CNT_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Read back; unmapped words read as zero
  always_comb begin
    unique case (reg_idx)
      REG_FAILSAFE: prdata = {{(APB_DATA_W-MV_W){1'b0}}, failsafe_pack_mv};
      REG_NOMINAL:  prdata = {{(APB_DATA_W-MAH_W){1'b0}}, nominal_capacity_mah};
      REG_RESERVE:  prdata = {{(APB_DATA_W-MAH_W){1'b0}}, reserve_capacity_mah};
      REG_RATE:     prdata = {{(APB_DATA_W-RATE_W){1'b0}}, discharge_rate_q4};
      REG_SAMPLES:  prdata = {{(APB_DATA_W-CNT_W){1'b0}}, power_on_samples};
      default:      prdata = '0;
    endcase
  end

  // floor(mv / 3200) by reciprocal multiply; exact over the 16-bit range
  assign cell_prod = failsafe_pack_mv * CELL_RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells <= '0;
    end else begin
      cells <= cell_prod[CELL_SHIFT+CELLS_W-1:CELL_SHIFT];
    end
  end

  // Sequencer: accepts in idle, steps through the divisions
  bce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (telemetry.valid),
    .in_ready (telemetry.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: state, curve, shared divider and the output register
  bce_datapath #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_datapath (
    .clk                      (clk),
    .rst                      (rst),
    .cmd                      (cmd),
    .st                       (st),
    .func                     (telemetry.func),
    .pack_mv                  (telemetry.pack_mv),
    .autopilot_percent        (telemetry.autopilot_percent),
    .nominal_capacity_mah     (nominal_capacity_mah),
    .reserve_capacity_mah     (reserve_capacity_mah),
    .discharge_rate_q4        (discharge_rate_q4),
    .power_on_samples         (power_on_samples),
    .cells                    (cells),
    .out_valid                (estimate.valid),
    .out_ready                (estimate.ready),
    .out_remaining_mah        (estimate.remaining_mah),
    .out_remaining_seconds    (estimate.remaining_seconds),
    .out_usable_percent       (estimate.usable_percent),
    .out_initial_capacity_mah (estimate.initial_capacity_mah),
    .out_cells                (estimate.cells),
    .out_power_on_done        (estimate.power_on_done)
  );

`ifndef NO_ASSERTIONS
  // A divider result is always consumed by the step that launched it
  a_done_captured: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> cmd.capture)
    else $error("divider result not captured");

  // One item at a time: the core closes its input right after a beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    telemetry.valid && telemetry.ready |=> !telemetry.ready)
    else $error("second item accepted while busy");

  // The result register is loaded only when it is empty or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !estimate.valid || estimate.ready)
    else $error("pending estimate overwritten");

  // Usable percent stays capped
  a_pct_capped: assert property (@(posedge clk) disable iff (rst)
    estimate.valid |-> estimate.usable_percent <= PCT_FULL)
    else $error("usable percent above full");
`endif

endmodule

FILE: dv/tb_battery_charge_estimator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_charge_estimator_core
// Self-checking bench for the battery charge estimator core. A queue-fed
// driver offers telemetry beats with random gaps, a monitor takes estimate
// beats with random stalls, and a cycle-free copy of the charge arithmetic
// predicts every estimate, which is compared field by field in order. The
// APB registers are rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_battery_charge_estimator_core;
  import bce_pkg::*;

  localparam int                CURVE_POINTS = 9;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;
  localparam int unsigned       RATE_ONE_Q4  = 16;       // 1 mAh/s in q4
  localparam int unsigned       RATE_MAX     = (1 << RATE_W) - 1;
  localparam int unsigned       MAX_U16      = 65535;
  localparam int                LONG_HOLD    = 400;      // receiver hold-off, cycles
  localparam int                DRAIN_CYCLES = 120;      // longer than the slowest recalc
  localparam int                PHASES       = 10;
  localparam int                PHASE_ITEMS  = 83;
  localparam int                TIMEOUT_NS   = 10_000_000;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [MV_W-1:0]   mv;
    logic [PCT_W-1:0]  pct;
  } telem_t;

  typedef struct packed {
    logic [MAH_W-1:0]   rem_mah;
    logic [SEC_W-1:0]   secs;
    logic [PCT_W-1:0]   usable;
    logic [MAH_W-1:0]   init_mah;
    logic [CELLS_W-1:0] cells;
    logic               done;
  } estimate_t;

  typedef struct packed {
    int mv;
    int pct;
  } knee_t;

  // Clock, reset and every block input start at known values.
  logic clk = 1'b0;
  logic rst = 1'b1;

  telem_t tel_beat  = '0;
  logic   tel_valid = 1'b0;
  logic   est_ready = 1'b0;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bce_in_if  tel_if ();
  bce_out_if est_if ();

  assign tel_if.valid             = tel_valid;
  assign tel_if.func              = tel_beat.func;
  assign tel_if.pack_mv           = tel_beat.mv;
  assign tel_if.autopilot_percent = tel_beat.pct;
  assign est_if.ready             = est_ready;

  battery_charge_estimator_core #(
    .CURVE_POINTS(CURVE_POINTS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .telemetry (tel_if),
    .estimate  (est_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the register file, updated on each APB write.
  logic [MV_W-1:0]   cfg_failsafe = '0;
  logic [MAH_W-1:0]  cfg_nominal  = '0;
  logic [MAH_W-1:0]  cfg_reserve  = '0;
  logic [RATE_W-1:0] cfg_rate     = RATE_RESET;
  logic [CNT_W-1:0]  cfg_samples  = SAMPLES_RESET;

  // Predicted estimator state.
  logic [MV_W-1:0]   peak_mv    = '0;
  logic [CNT_W-1:0]  sample_cnt = '0;
  logic [MAH_W-1:0]  init_mah   = '0;
  logic [PCT_W-1:0]  ap_pct     = '0;

  telem_t    pending_items[$];   // beats waiting for the driver
  estimate_t due_estimates[$];   // estimates owed by the core, oldest first

  int   fault_count = 0;
  int   src_gap     = 0;
  int   sink_gap    = 0;
  int   hold_left   = 0;
  int   hold_reqs   = 0;
  int   hold_served = 0;
  logic idle_on     = 1'b1;      // random gaps and stalls enabled

  // --------------------------------------------------------------------------
  // Charge arithmetic
  // --------------------------------------------------------------------------

  // Per-cell discharge curve, highest voltage first.
  function automatic knee_t knee(int idx);
    knee_t k;
    case (idx)
      0:       k = '{4200, 100};
      1:       k = '{4100, 95};
      2:       k = '{4000, 85};
      3:       k = '{3950, 77};
      4:       k = '{3810, 56};
      5:       k = '{3750, 50};
      6:       k = '{3700, 25};
      7:       k = '{3650, 17};
      8:       k = '{3430, 8};
      default: k = '{0, 0};
    endcase
    return k;
  endfunction

  // Charge percent of one cell: walk the knees upward from the 3.2 V floor
  // and interpolate inside the first segment that holds the voltage.
  function automatic int curve_percent(int cell_mv);
    int    lo_mv;
    int    lo_pct;
    int    span;
    int    r;
    knee_t k;
    lo_mv  = CELL_FLOOR_MV;
    lo_pct = 0;
    if (cell_mv <= lo_mv) return 0;
    for (int i = CURVE_POINTS - 1; i >= 0; i--) begin
      k = knee(i & 15);
      if (cell_mv <= k.mv) begin
        span = k.mv - lo_mv;
        if (span <= 0) return 0;
        r = lo_pct + ((cell_mv - lo_mv) * (k.pct - lo_pct)) / span;
        if (r < 0) r = 0;
        if (r > 100) r = 100;
        return r;
      end
      lo_mv  = k.mv;
      lo_pct = k.pct;
    end
    return 100;
  endfunction

  // Apply one accepted telemetry beat and return the estimate it produces.
  function automatic estimate_t charge_step(telem_t t);
    int unsigned cells;
    int unsigned total;
    int unsigned rem;
    int unsigned secs;
    int unsigned upct;
    estimate_t   e;
    cells = cfg_failsafe / CELL_FLOOR_MV;
    case (t.func)
      FUNC_SAMPLE: begin
        // Track the peak only while power-on sampling is open.
        if (sample_cnt < cfg_samples) begin
          if (t.mv > peak_mv) peak_mv = t.mv;
          sample_cnt = sample_cnt + 1'b1;
        end
      end
      FUNC_PERCENT: begin
        ap_pct = (t.pct > PCT_FULL) ? PCT_FULL : t.pct;
      end
      FUNC_RECALC: begin
        // Fix the initial capacity once, and only with everything known.
        if (sample_cnt >= cfg_samples && init_mah == '0 && cells != 0 &&
            peak_mv != '0 && cfg_nominal != '0) begin
          init_mah = MAH_W'((cfg_nominal * curve_percent(peak_mv / cells)) / PCT_FULL);
        end
      end
      default: begin
      end
    endcase

    total = ap_pct * init_mah;
    total = total / PCT_FULL;
    rem   = (total > cfg_reserve) ? total - cfg_reserve : 0;
    if (rem > MAX_U16) rem = MAX_U16;

    secs = 0;
    if (cfg_rate > RATE_ONE_Q4) begin
      secs = (rem * RATE_ONE_Q4) / cfg_rate;
      if (secs > MAX_U16) secs = MAX_U16;
    end

    upct = 0;
    if (cfg_nominal > cfg_reserve) begin
      upct = (rem * PCT_FULL) / (cfg_nominal - cfg_reserve);
      if (upct > PCT_FULL) upct = PCT_FULL;
    end

    e.rem_mah  = MAH_W'(rem);
    e.secs     = SEC_W'(secs);
    e.usable   = PCT_W'(upct);
    e.init_mah = init_mah;
    e.cells    = CELLS_W'(cells);
    e.done     = (sample_cnt >= cfg_samples);
    return e;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: feed telemetry beats from the pending queue
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      tel_valid <= 1'b0;
    end else begin
      // Predict on acceptance, while the config is stable.
      if (tel_valid && tel_if.ready) begin
        due_estimates.push_back(charge_step(tel_beat));
      end
      // Hold a beat that is not taken yet; otherwise advance.
      if (!tel_valid || tel_if.ready) begin
        if (src_gap != 0) begin
          src_gap--;
          tel_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          tel_beat  <= pending_items.pop_front();
          tel_valid <= 1'b1;
          // Open a burst of idle cycles after this beat now and then.
          if (idle_on && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(1, 17);
          end
        end else begin
          tel_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, counted here, started by the stimulus
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_served) begin
      hold_left   <= LONG_HOLD;
      hold_served <= hold_reqs;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take estimate beats and check them against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    estimate_t want;
    estimate_t got;
    if (rst) begin
      est_ready <= 1'b0;
    end else begin
      if (est_if.valid && est_ready) begin
        got = '{est_if.remaining_mah, est_if.remaining_seconds, est_if.usable_percent,
                est_if.initial_capacity_mah, est_if.cells, est_if.power_on_done};
        if (due_estimates.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: estimate beat with no prediction pending", $realtime);
          end
        end else begin
          want = due_estimates.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("%0t: estimate mismatch, expected rem=%0d s=%0d pct=%0d init=%0d %s",
                       $realtime, want.rem_mah, want.secs, want.usable, want.init_mah,
                       $sformatf("cells=%0d done=%0d", want.cells, want.done));
              $display("%0t:                    actual rem=%0d s=%0d pct=%0d init=%0d %s",
                       $realtime, got.rem_mah, got.secs, got.usable, got.init_mah,
                       $sformatf("cells=%0d done=%0d", got.cells, got.done));
            end
          end
        end
      end
      // Drop ready during a long hold or a random stall burst.
      if (hold_left != 0) begin
        est_ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        est_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(1, 17) - 1;
        est_ready <= 1'b0;
      end else begin
        est_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // APB write: setup cycle, access cycle, register loads at the access edge.
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_FAILSAFE: cfg_failsafe = MV_W'(value);
      REG_NOMINAL:  cfg_nominal  = MAH_W'(value);
      REG_RESERVE:  cfg_reserve  = MAH_W'(value);
      REG_RATE:     cfg_rate     = RATE_W'(value);
      REG_SAMPLES:  cfg_samples  = CNT_W'(value);
      default: begin
      end
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input int unsigned fs, input int unsigned nom,
                           input int unsigned res, input int unsigned rate,
                           input int unsigned samp);
    apb_write(REG_FAILSAFE, fs);
    apb_write(REG_NOMINAL, nom);
    apb_write(REG_RESERVE, res);
    apb_write(REG_RATE, rate);
    apb_write(REG_SAMPLES, samp);
    @(negedge clk);
  endtask

  task automatic offer(input logic [FUNC_W-1:0] f, input int unsigned mv,
                       input int unsigned pc);
    pending_items.push_back('{f, MV_W'(mv), PCT_W'(pc)});
  endtask

  // Mostly percent updates, then samples, recalcs and the unused code.
  task automatic offer_random();
    int unsigned pick;
    int unsigned pc;
    pick = $urandom_range(0, 9);
    pc   = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
    if (pick < 5)      offer(FUNC_PERCENT, $urandom, pc);
    else if (pick < 7) offer(FUNC_SAMPLE, $urandom_range(0, MAX_U16), $urandom);
    else if (pick < 9) offer(FUNC_RECALC, $urandom, $urandom);
    else               offer(FUNC_UNUSED, $urandom, $urandom);
  endtask

  // Sender pause: wait until every owed estimate has come back.
  task automatic wait_idle();
    while (pending_items.size() != 0 || tel_valid || due_estimates.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          c;
    int          u;
    int          peak_goal;
    int          ofs_max;
    int unsigned fs_cells;
    int unsigned nom_fix;
    int unsigned fs;
    int unsigned nom;
    int unsigned res;
    int unsigned rate;
    int unsigned samp;
    knee_t       k;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Pick a cell count and a per-cell peak that lands somewhere on the
    // curve, often right on a knee or one millivolt above it.
    c = $urandom_range(1, 20);
    if ($urandom_range(0, 2) == 0) begin
      k = knee($urandom_range(0, CURVE_POINTS - 1));
      u = k.mv + $urandom_range(0, 1);
    end else begin
      u = $urandom_range(3150, 4300);
    end
    peak_goal = c * u;
    if (peak_goal > MAX_U16) peak_goal = MAX_U16;
    ofs_max = MAX_U16 - 3200 * c;
    if (ofs_max > 3199) ofs_max = 3199;
    fs_cells = 3200 * c + $urandom_range(0, ofs_max);
    nom_fix  = $urandom_range(1000, MAX_U16);

    // Power-on: recalc before sampling is done, clamp of a high percent,
    // the unused code, then ten samples that end on the peak.
    configure(0, 0, 0, RATE_RESET, SAMPLES_RESET);
    offer(FUNC_RECALC, 0, 0);
    offer(FUNC_PERCENT, 0, 127);
    offer(FUNC_UNUSED, MAX_U16, 127);
    offer(FUNC_SAMPLE, 0, 0);
    repeat (8) offer(FUNC_SAMPLE, $urandom_range(0, peak_goal), $urandom);
    offer(FUNC_SAMPLE, peak_goal, 0);
    // Sampling is closed now: a full-scale sample must leave the peak alone.
    offer(FUNC_SAMPLE, MAX_U16, 0);
    offer(FUNC_RECALC, 0, 0);              // no cells yet
    offer(FUNC_PERCENT, 0, 0);
    wait_idle();

    // Cells known, nominal still zero: recalc must not fire.
    configure(fs_cells, 0, 0, RATE_RESET, SAMPLES_RESET);
    offer(FUNC_RECALC, 0, 0);
    wait_idle();

    // Twenty cells pull the per-cell voltage to the floor: capacity stays zero.
    if (peak_goal / 20 <= 3200) begin
      configure(MAX_U16, MAX_U16, 0, RATE_RESET, SAMPLES_RESET);
      offer(FUNC_RECALC, 0, 0);
      offer(FUNC_PERCENT, 0, 100);
      wait_idle();
    end

    // Fix the initial capacity, then try again: the second recalc is ignored.
    configure(fs_cells, nom_fix, $urandom_range(0, nom_fix / 8), RATE_RESET, SAMPLES_RESET);
    offer(FUNC_PERCENT, 0, 100);
    offer(FUNC_RECALC, 0, 0);
    offer(FUNC_RECALC, 0, 0);
    offer(FUNC_PERCENT, 0, $urandom_range(2, 99));
    offer(FUNC_PERCENT, 0, 1);
    wait_idle();

    // Random phases, each with its own register setting; the early ones
    // take the extremes of every register.
    for (int p = 0; p < PHASES; p++) begin
      fs   = $urandom_range(0, MAX_U16);
      nom  = $urandom_range(0, MAX_U16);
      res  = $urandom_range(0, init_mah);
      rate = $urandom_range(0, RATE_MAX);
      samp = $urandom_range(1, 255);
      case (p)
        0: begin
          fs = 0; nom = MAX_U16; res = 0; rate = RATE_MAX; samp = 255;
        end
        1: begin
          fs = MAX_U16; nom = 0; res = MAX_U16; rate = 0; samp = 1;
        end
        2: begin
          // Nominal equal to reserve, rate exactly at the cutoff.
          res = nom; rate = RATE_ONE_Q4;
        end
        3: begin
          // Nominal below reserve, slowest rate that still counts.
          nom = $urandom_range(0, 60000); res = nom + $urandom_range(1, 5000);
          rate = RATE_ONE_Q4 + 1;
        end
        4: begin
          // Nominal cut below the fixed capacity, sampling closed from zero.
          nom = init_mah / 4 + 1; res = 0; samp = 0;
        end
        default: begin
        end
      endcase
      configure(fs, nom, res, rate, samp);
      // Run the last phases without any gaps or stalls.
      idle_on = (p < PHASES - 2);
      // Hold the receiver off while beats keep coming, so the core backs up.
      if (p == 3) hold_reqs++;
      repeat (PHASE_ITEMS) offer_random();
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    fault_count += due_estimates.size();
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Bound the run well past the slowest legal schedule.
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
sv/bce_pkg.sv
sv/bce_if.sv
sv/bce_div.sv
sv/bce_datapath.sv
sv/bce_ctrl.sv
sv/battery_charge_estimator_core.sv
dv/tb_battery_charge_estimator_core.sv
